@@ hw/rtl/itcp_pkg.sv @@
// ----------------------------------------------------------------------------
// IPv4/TCP header deframer package
// Shared constants, record kinds and the queue entry type.
// ----------------------------------------------------------------------------
package itcp_pkg;

  // Fixed header sizes in bytes.
  localparam int unsigned IP_FIXED_BYTES  = 20;
  localparam int unsigned TCP_FIXED_BYTES = 28;

  // Header length fields above these word counts carry option bytes.
  localparam logic [3:0] IP_FIXED_WORDS  = 4'd5;
  localparam logic [3:0] TCP_FIXED_WORDS = 4'd7;

  // Byte positions of interest inside the fixed parts.
  localparam logic [5:0] POS_IHL       = 6'd0;
  localparam logic [5:0] POS_TOTLEN_HI = 6'd2;
  localparam logic [5:0] POS_TOTLEN_LO = 6'd3;
  localparam logic [5:0] POS_SRC_FIRST = 6'd12;
  localparam logic [5:0] POS_SRC_LAST  = 6'd15;
  localparam logic [5:0] POS_DST_FIRST = 6'd16;
  localparam logic [5:0] POS_DST_LAST  = 6'd19;
  localparam logic [5:0] POS_TCP_OFS   = 6'd12;

  // Default depth of the queue between parser and output stage.
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // Width of the packed output data word (113 bits rounded up to bytes).
  localparam int unsigned OUT_TDATA_W = 120;

  // Record kinds, carried on tuser.
  localparam logic REC_HEADER  = 1'b0;
  localparam logic REC_PAYLOAD = 1'b1;

  // One request from the parser to the output stage.
  typedef struct packed {
    logic        kind;
    logic        last;
    logic [7:0]  data_byte;
    logic [3:0]  ihl;
    logic [15:0] total_length;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [3:0]  tcp_offset;
    logic [15:0] payload_length;
    logic        length_error;
  } itcp_entry_t;

endpackage

@@ hw/rtl/itcp_front.sv @@
// ----------------------------------------------------------------------------
// IPv4/TCP header parser front end
// Walks the header phases byte by byte and posts header and payload requests.
// ----------------------------------------------------------------------------
module itcp_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 byte_valid_i,
  input  logic [7:0]           byte_i,
  input  logic                 queue_full_i,
  output logic                 byte_ready_o,
  output logic                 push_o,
  output itcp_pkg::itcp_entry_t push_entry_o
);
  import itcp_pkg::*;

  typedef enum logic [4:0] {
    PH_IPFIX  = 5'b00001,
    PH_IPOPT  = 5'b00010,
    PH_TCPFIX = 5'b00100,
    PH_TCPOPT = 5'b01000,
    PH_DATA   = 5'b10000
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [5:0]  pos_q, pos_d;
  logic [3:0]  ihl_q, ihl_d;
  logic [15:0] tot_q, tot_d;
  logic [31:0] src_q, src_d;
  logic [31:0] dst_q, dst_d;
  logic [3:0]  ofs_q, ofs_d;
  logic [15:0] rem_q, rem_d;

  logic        accept;
  logic [6:0]  pos_inc;
  logic [6:0]  ip_opt_len;
  logic [6:0]  tcp_opt_len;
  logic [17:0] len_full;
  logic        len_err;
  logic [15:0] pl_len;
  logic        emit_hdr;
  logic        emit_pay;
  logic        pay_last;

  assign byte_ready_o = !queue_full_i;
  assign accept       = byte_valid_i && byte_ready_o;

  assign pos_inc     = {1'b0, pos_q} + 7'd1;
  assign ip_opt_len  = {1'b0, ihl_q, 2'b00} - 7'(IP_FIXED_BYTES);
  assign tcp_opt_len = {1'b0, ofs_q, 2'b00} - 7'(TCP_FIXED_BYTES);

  // Payload length from the held fields; a negative value saturates to zero.
  assign len_full = {2'b00, tot_q} - {12'd0, ihl_q, 2'b00} - {12'd0, ofs_q, 2'b00};
  assign len_err  = len_full[17];
  assign pl_len   = len_err ? 16'd0 : len_full[15:0];

  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    ihl_d    = ihl_q;
    tot_d    = tot_q;
    src_d    = src_q;
    dst_d    = dst_q;
    ofs_d    = ofs_q;
    rem_d    = rem_q;
    emit_hdr = 1'b0;
    emit_pay = 1'b0;
    pay_last = 1'b0;
    if (accept) begin
      unique case (phase_q)
        PH_IPFIX: begin
          if (pos_q == POS_IHL) begin
            ihl_d = byte_i[3:0];
          end else if (pos_q == POS_TOTLEN_HI) begin
            tot_d = {byte_i, 8'h00};
          end else if (pos_q == POS_TOTLEN_LO) begin
            tot_d = {tot_q[15:8], byte_i};
          end else if (pos_q >= POS_SRC_FIRST && pos_q <= POS_SRC_LAST) begin
            src_d = {src_q[23:0], byte_i};
          end else if (pos_q >= POS_DST_FIRST && pos_q <= POS_DST_LAST) begin
            dst_d = {dst_q[23:0], byte_i};
          end
          pos_d = pos_inc[5:0];
          if (pos_inc >= 7'(IP_FIXED_BYTES)) begin
            pos_d   = 6'd0;
            phase_d = (ihl_q > IP_FIXED_WORDS) ? PH_IPOPT : PH_TCPFIX;
          end
        end
        PH_IPOPT: begin
          pos_d = pos_inc[5:0];
          if (pos_inc >= ip_opt_len) begin
            pos_d   = 6'd0;
            phase_d = PH_TCPFIX;
          end
        end
        PH_TCPFIX: begin
          if (pos_q == POS_TCP_OFS) begin
            ofs_d = byte_i[7:4];
          end
          pos_d = pos_inc[5:0];
          if (pos_inc >= 7'(TCP_FIXED_BYTES)) begin
            pos_d = 6'd0;
            if (ofs_q > TCP_FIXED_WORDS) begin
              phase_d = PH_TCPOPT;
            end else begin
              emit_hdr = 1'b1;
            end
          end
        end
        PH_TCPOPT: begin
          pos_d = pos_inc[5:0];
          if (pos_inc >= tcp_opt_len) begin
            pos_d    = 6'd0;
            emit_hdr = 1'b1;
          end
        end
        PH_DATA: begin
          emit_pay = 1'b1;
          if (rem_q != 16'd0) begin
            rem_d = rem_q - 16'd1;
          end
          if (rem_d == 16'd0) begin
            pay_last = 1'b1;
            phase_d  = PH_IPFIX;
            pos_d    = 6'd0;
          end
        end
        default: begin
          phase_d = PH_IPFIX;
          pos_d   = 6'd0;
        end
      endcase
      if (emit_hdr) begin
        rem_d   = pl_len;
        phase_d = (pl_len != 16'd0) ? PH_DATA : PH_IPFIX;
      end
    end
  end

  always_comb begin
    push_entry_o                = '0;
    push_entry_o.kind           = emit_pay ? REC_PAYLOAD : REC_HEADER;
    push_entry_o.last           = emit_pay ? pay_last : (pl_len == 16'd0);
    push_entry_o.data_byte      = byte_i;
    push_entry_o.ihl            = ihl_q;
    push_entry_o.total_length   = tot_q;
    push_entry_o.src_addr       = src_q;
    push_entry_o.dst_addr       = dst_q;
    push_entry_o.tcp_offset     = ofs_q;
    push_entry_o.payload_length = pl_len;
    push_entry_o.length_error   = len_err;
  end

  assign push_o = emit_hdr || emit_pay;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IPFIX;
      pos_q   <= 6'd0;
      ihl_q   <= 4'd0;
      tot_q   <= 16'd0;
      src_q   <= 32'd0;
      dst_q   <= 32'd0;
      ofs_q   <= 4'd0;
      rem_q   <= 16'd0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      ihl_q   <= ihl_d;
      tot_q   <= tot_d;
      src_q   <= src_d;
      dst_q   <= dst_d;
      ofs_q   <= ofs_d;
      rem_q   <= rem_d;
    end
  end

`ifndef SYNTHESIS
  // The payload phase is only entered with bytes left to deliver.
  a_data_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> rem_q != 16'd0)
    else $error("payload phase with no bytes remaining");

  // A saturated payload length closes the packet on the header record.
  a_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_hdr && len_err |-> push_entry_o.last && phase_d == PH_IPFIX)
    else $error("length error header did not end the packet");

  // The position counter stays within the fixed IP header.
  a_ipfix_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_IPFIX |-> pos_q < 6'(IP_FIXED_BYTES))
    else $error("IP header position out of range");
`endif

endmodule

@@ hw/rtl/itcp_queue.sv @@
// ----------------------------------------------------------------------------
// IPv4/TCP deframer request queue
// Small circular buffer between parser and output stage.
// ----------------------------------------------------------------------------
module itcp_queue #(
  parameter int unsigned DEPTH = itcp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  itcp_pkg::itcp_entry_t push_entry_i,
  input  logic                  pop_i,
  output logic                  full_o,
  output logic                  valid_o,
  output itcp_pkg::itcp_entry_t head_o
);
  import itcp_pkg::*;

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  itcp_entry_t       slots_q [DEPTH];
  logic [IDX_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [IDX_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = slots_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_q + IDX_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_q + IDX_W'(1);
    end
    if (push_i && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (!push_i && do_pop) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

@@ hw/rtl/itcp_back.sv @@
// ----------------------------------------------------------------------------
// IPv4/TCP deframer output stage
// Formats queued requests into records and holds them in an output register.
// ----------------------------------------------------------------------------
module itcp_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            head_valid_i,
  input  itcp_pkg::itcp_entry_t           head_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [itcp_pkg::OUT_TDATA_W-1:0] out_data_o,
  output logic                            out_kind_o,
  output logic                            out_last_o
);
  import itcp_pkg::*;

  logic                   valid_q, valid_d;
  logic [OUT_TDATA_W-1:0] data_q, data_d;
  logic                   kind_q, kind_d;
  logic                   last_q, last_d;
  logic                   load;

  assign load  = head_valid_i && (!valid_q || out_ready_i);
  assign pop_o = load;

  // Payload records carry only the byte; header records carry no byte.
  always_comb begin
    data_d = '0;
    kind_d = head_i.kind;
    last_d = head_i.last;
    if (head_i.kind == REC_PAYLOAD) begin
      data_d[112:105] = head_i.data_byte;
    end else begin
      data_d[3:0]     = head_i.ihl;
      data_d[19:4]    = head_i.total_length;
      data_d[51:20]   = head_i.src_addr;
      data_d[83:52]   = head_i.dst_addr;
      data_d[87:84]   = head_i.tcp_offset;
      data_d[103:88]  = head_i.payload_length;
      data_d[104]     = head_i.length_error;
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
      kind_q <= kind_d;
      last_q <= last_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;
  assign out_kind_o  = kind_q;
  assign out_last_o  = last_q;

endmodule

@@ hw/rtl/ipv4_tcp_header_deframer.sv @@
// ----------------------------------------------------------------------------
// IPv4/TCP header deframer
// Splits a byte stream of back-to-back IPv4+TCP packets into header records
// and payload byte records.
// ----------------------------------------------------------------------------
// Channel   Dir  Width  Contents
// s_axis    in   8      tdata: stream_byte
// m_axis    out  120    tdata: header fields or payload byte, tuser: record_kind,
//                       tlast: last_of_packet
//
// The parser handles stream bytes as they are accepted; one byte per clock is
// accepted as long as the request queue has room, and the queue drains one
// record per clock into the output register while that register is empty or m_axis takes its record.
// An accepted byte's record is written into the queue and then into the output register.
// Reset returns the parser to the start of an IP header with all held fields
// cleared and empties the queue and output register.
// A stall on m_axis fills the queue first; s_axis tready drops only once the
// queue is full.
// ----------------------------------------------------------------------------
module ipv4_tcp_header_deframer #(
  parameter int unsigned QUEUE_DEPTH = itcp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Input byte stream.
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,   // [7:0] stream_byte
  // Output record stream.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // From bit 0 up: ip_header_words[3:0], total_length[19:4],
  // source_address[51:20], destination_address[83:52],
  // tcp_header_words[87:84], payload_length[103:88], length_error[104],
  // payload_byte[112:105], zero fill[119:113].
  output logic [itcp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                             m_axis_tuser,   // [0] record_kind
  output logic                             m_axis_tlast    // last_of_packet
);
  import itcp_pkg::*;

  // Requests between the parser and the queue.
  logic        push;
  itcp_entry_t push_entry;
  logic        queue_full;

  // Queue head toward the output stage.
  logic        head_valid;
  itcp_entry_t head;
  logic        pop;

  // The parser tracks the header phase, captures the header fields and
  // posts one request for the header record and one per payload byte.
  itcp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (s_axis_tvalid),
    .byte_i       (s_axis_tdata),
    .queue_full_i (queue_full),
    .byte_ready_o (s_axis_tready),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  // The queue lets the parser keep taking bytes while the output waits.
  itcp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .full_o       (queue_full),
    .valid_o      (head_valid),
    .head_o       (head)
  );

  // The output stage packs the record and presents it on m_axis.
  itcp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_axis_tdata),
    .out_kind_o   (m_axis_tuser),
    .out_last_o   (m_axis_tlast)
  );

endmodule
